@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, suspended while reset is high.
`define MRB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check on every rising edge, reset included.
`define MRB_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

@@ src/mrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 1024;

   localparam int COL_W   = $clog2(MAX_COLS);        // column index
   localparam int DEPTH_W = $clog2(MAX_COLS + 1);    // stack depth, column count
   localparam int H_W     = $clog2(MAX_ROWS + 1);    // column height
   localparam int AREA_W  = 17;
   localparam int PROD_W  = H_W + DEPTH_W;

   localparam logic [H_W-1:0]     MAX_HEIGHT = H_W'(MAX_ROWS);
   localparam logic [AREA_W-1:0]  AREA_CAP   = {AREA_W{1'b1}};
   localparam logic [DEPTH_W-1:0] WIDTH_MAX  = DEPTH_W'(MAX_COLS);
   localparam logic [DEPTH_W-1:0] WIDTH_RST  = DEPTH_W'(64);

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ROW_WIDTH = 1'b0;             // word index of row_width

   // One stack entry: column, left edge of its rectangle, height
   typedef struct packed {
      logic [COL_W-1:0]   idx;
      logic [DEPTH_W-1:0] left;
      logic [H_W-1:0]     height;
   } stack_entry_type;

   // Controller -> datapath
   typedef struct packed {
      logic accept;       // latch item, read its column height
      logic upd_height;   // update and store the column height
      logic pop;          // pop top, form its area, read the entry below
      logic load;         // take the entry below as new top, fold area into best
      logic push;         // push the current column
      logic flush_start;  // start the end-of-row sentinel sweep
      logic advance;      // move to the next column
      logic row_done;     // empty the stack, back to column zero
      logic emit;         // deliver best area and clear the matrix
   } mrb_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic can_pop;
      logic end_row;
      logic is_last;
      logic rsp_free;
   } mrb_status_type;

endpackage

`default_nettype wire

@@ src/mrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrb_ctrl
// Sequencer: height update, pop loop, push, end-of-row flush, result emit.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_ctrl import mrb_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire mrb_status_type status,
   output mrb_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HREAD,
      ST_CHECK,
      ST_LOAD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      flush_ff, flush_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      flush_in = flush_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_HREAD;
            end
         end
         ST_HREAD: begin
            cmd.upd_height = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.can_pop) begin
               cmd.pop  = 1'b1;
               state_in = ST_LOAD;
            end else if (!flush_ff) begin
               cmd.push = 1'b1;
               if (status.end_row) begin
                  cmd.flush_start = 1'b1;
                  flush_in        = 1'b1;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.row_done = 1'b1;
               flush_in     = 1'b0;
               state_in     = status.is_last ? ST_EMIT : ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_CHECK;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         flush_ff <= flush_in;
      end
   end

endmodule

`default_nettype wire

@@ src/mrb_dpath.sv @@
// ----------------------------------------------------------------------------
// mrb_dpath
// Height memory, index stack memory, area multiply and best-area tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_dpath import mrb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mrb_cmd_type        cmd,
   output mrb_status_type          status,
   input  wire logic               in_cell,
   input  wire logic               in_last,
   input  wire logic [DEPTH_W-1:0] width_eff,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [AREA_W-1:0]       rsp_area
);

   logic [H_W-1:0]    height_mem [MAX_COLS];
   stack_entry_type   stack_mem  [MAX_COLS];

   logic [MAX_COLS-1:0] hvalid_ff;
   logic                cell_ff, last_ff;
   logic [COL_W-1:0]    col_ff;
   logic [H_W-1:0]      hrd_ff;
   logic                hrd_valid_ff;
   logic [H_W-1:0]      cur_ff;
   logic [DEPTH_W-1:0]  sweep_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   stack_entry_type     top_ff, srd_ff;
   logic [AREA_W-1:0]   prod_ff, best_ff;
   logic                rsp_valid_ff;
   logic [AREA_W-1:0]   rsp_area_ff;

   logic [H_W-1:0]      h_old, h_new;
   logic [DEPTH_W-1:0]  span;
   logic [PROD_W-1:0]   prod_full;
   logic [AREA_W-1:0]   prod_cap;
   logic [COL_W-1:0]    below_addr;
   stack_entry_type     push_entry;
   logic [DEPTH_W-1:0]  col_next;

   assign col_next = {1'b0, col_ff} + DEPTH_W'(1);
   assign h_old    = hrd_valid_ff ? hrd_ff : '0;

   always_comb begin
      if (!cell_ff)                h_new = '0;
      else if (h_old < MAX_HEIGHT) h_new = h_old + H_W'(1);
      else                         h_new = MAX_HEIGHT;
   end

   assign span       = (sweep_ff >= top_ff.left) ? (sweep_ff - top_ff.left) : '0;
   assign prod_full  = PROD_W'(top_ff.height) * PROD_W'(span);
   assign prod_cap   = (prod_full > PROD_W'(AREA_CAP)) ? AREA_CAP : prod_full[AREA_W-1:0];
   assign below_addr = COL_W'(depth_ff - DEPTH_W'(2));

   assign push_entry.idx    = col_ff;
   assign push_entry.left   = (depth_ff != '0) ? ({1'b0, top_ff.idx} + DEPTH_W'(1)) : '0;
   assign push_entry.height = cur_ff;

   assign status.can_pop  = (depth_ff != '0) && (cur_ff <= top_ff.height);
   assign status.end_row  = (col_next >= width_eff) || last_ff;
   assign status.is_last  = last_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_area  = rsp_area_ff;

   // Memories: registered reads, single write port each
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hrd_ff <= height_mem[col_ff];
      end
      if (cmd.upd_height) begin
         height_mem[col_ff] <= h_new;
      end
      if (cmd.pop) begin
         srd_ff <= stack_mem[below_addr];
      end
      if (cmd.push) begin
         stack_mem[depth_ff[COL_W-1:0]] <= push_entry;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cell_ff      <= in_cell;
         last_ff      <= in_last;
         hrd_valid_ff <= hvalid_ff[col_ff];
      end
      if (cmd.upd_height) begin
         cur_ff   <= h_new;
         sweep_ff <= {1'b0, col_ff};
      end
      if (cmd.flush_start) begin
         cur_ff   <= '0;
         sweep_ff <= col_next;
      end
      if (cmd.pop) begin
         prod_ff <= prod_cap;
      end
      if (cmd.push) begin
         top_ff <= push_entry;
      end else if (cmd.load) begin
         top_ff <= srd_ff;
      end
      if (cmd.emit) begin
         rsp_area_ff <= best_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff    <= '0;
         col_ff       <= '0;
         depth_ff     <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.upd_height) begin
            hvalid_ff[col_ff] <= 1'b1;
         end
         if (cmd.advance) begin
            col_ff <= col_next[COL_W-1:0];
         end
         priority if (cmd.pop) begin
            depth_ff <= depth_ff - DEPTH_W'(1);
         end else if (cmd.push) begin
            depth_ff <= depth_ff + DEPTH_W'(1);
         end else if (cmd.row_done) begin
            depth_ff <= '0;
         end
         if (cmd.row_done) begin
            col_ff <= '0;
         end
         if (cmd.load && (prod_ff > best_ff)) begin
            best_ff <= prod_ff;
         end
         if (cmd.emit) begin
            best_ff      <= '0;
            hvalid_ff    <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/maximal_rectangle_binary_matrix.sv @@
// ----------------------------------------------------------------------------
// maximal_rectangle_binary_matrix
// Largest all-ones rectangle of a binary matrix streamed one cell per item.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one matrix cell per item, row-major; req_tdata[0] is the
//   cell, req_tlast marks the final cell of the matrix. Rows are row_width
//   cells long (CSR at byte address 0, bits [6:0]; values 0 and above 64 act as 1 / 64).
//   rsp channel: one item per matrix, the largest rectangle area, sent after
//   the item marked last; the block then starts a fresh matrix.
// Sequence: a cell is accepted, its height read and updated, then it pops
//   every entry not lower than it and is pushed; the cell that ends a row adds
//   the flush pops and the last cell the result. Each pop needs the LOAD state
//   after CHECK, as the entry below the top is a registered stack memory read.
//   req_tready is high only while the sequencer is idle.
// Reset: heights, stack, column and best area clear, row_width returns to 64.
//   Heights are cleared at once through per-column valid bits, no sweep.
// Stall: a result waits in the rsp output register; new cells are still
//   taken, and only the next matrix result waits for the register to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_rectangle_binary_matrix import mrb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input cells
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [0] cell_req, [7:1] zero
   input  wire logic                  req_tlast,   // last cell of the matrix
   // results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [23:0]                rsp_tdata,   // [16:0] max_area, [23:17] zero
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   mrb_cmd_type         cmd;
   mrb_status_type      status;
   logic [DEPTH_W-1:0]  row_width_ff;
   logic [DEPTH_W-1:0]  width_eff;
   logic [AREA_W-1:0]   rsp_area;
   logic                csr_write;
   logic                csr_sel_width;

   // CSR: single register, word index from paddr[2], no wait states
   assign csr_pready    = 1'b1;
   assign csr_sel_width = (csr_paddr[2] == REG_ROW_WIDTH);
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata    = csr_sel_width ? CSR_DATA_W'(row_width_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_RST;
      end else if (csr_write && csr_sel_width) begin
         row_width_ff <= csr_pwdata[DEPTH_W-1:0];
      end
   end

   // Clamp the row width into 1..MAX_COLS
   always_comb begin
      priority if (row_width_ff == '0)      width_eff = DEPTH_W'(1);
      else if (row_width_ff > WIDTH_MAX)    width_eff = WIDTH_MAX;
      else                                  width_eff = row_width_ff;
   end

   mrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mrb_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_cell   (req_tdata[0]),
      .in_last   (req_tlast),
      .width_eff (width_eff),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_area  (rsp_area)
   );

   // Pad the area to whole bytes
   assign rsp_tdata = {{(24 - AREA_W){1'b0}}, rsp_area};

endmodule

`default_nettype wire

@@ src/mrb_checker.sv @@
// ----------------------------------------------------------------------------
// mrb_checker
// Port-level checks on the rectangle block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mrb_checker import mrb_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [23:0]           rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // Hold a stalled result
   `MRB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // No result survives reset
   `MRB_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid)
   // Busy for at least the height read after taking a cell
   `MRB_ASSERT(a_busy_after_item, clock, reset, req_fire |=> !req_tready)
   // Area never exceeds its field, padding stays zero
   `MRB_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[23:AREA_W] == '0)

endmodule

bind maximal_rectangle_binary_matrix mrb_checker u_mrb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);

`default_nettype wire
